### rtl/core/wev_pkg.sv
// Shared types and constants of the windowed encoder velocity block.
// Used by wev_front, wev_back and the top level; depends on nothing.
package wev_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned WINDOW_DEF   = 16;

  localparam logic [1:0] FUNC_EVENT   = 2'd0;
  localparam logic [1:0] FUNC_POLL    = 2'd1;
  localparam logic [1:0] FUNC_PUBLISH = 2'd2;

  localparam logic CFG_TICK_SCALE      = 1'b0;
  localparam logic CFG_ACTIVE_CHANNELS = 1'b1;

  localparam logic [31:0] US_PER_S = 32'd1000000;

  typedef enum logic [1:0] {
    OP_EVENT,
    OP_POLL,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         channel;
    logic signed [15:0] tick_delta;
    logic [31:0]        timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        sequence_res;
    logic [1:0]         wheel;
    logic signed [47:0] position_rad;
    logic signed [31:0] velocity_rad_s;
    logic               last;
  } out_word_t;

  typedef struct packed {
    op_e                op;
    logic [1:0]         channel;
    logic signed [15:0] delta;
    logic [31:0]        stamp;
  } cmd_t;

endpackage

### rtl/core/wev_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on wev_pkg.
module wev_front #(
  parameter int unsigned CHANNELS = wev_pkg::CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wev_pkg::in_word_t in_i,
  output logic              cmd_valid_o,
  output wev_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  wev_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          keep, push, pop;
  wev_pkg::cmd_t cmd_new;

  always_comb begin
    keep         = 1'b0;
    cmd_new.op   = wev_pkg::OP_EVENT;
    cmd_new.channel = in_i.channel;
    cmd_new.delta   = in_i.tick_delta;
    cmd_new.stamp   = in_i.timestamp_us;
    case (in_i.func)
      wev_pkg::FUNC_EVENT: begin
        keep = 32'(in_i.channel) < 32'(CHANNELS);
      end
      wev_pkg::FUNC_POLL: begin
        keep       = 1'b1;
        cmd_new.op = wev_pkg::OP_POLL;
      end
      wev_pkg::FUNC_PUBLISH: begin
        keep       = 1'b1;
        cmd_new.op = wev_pkg::OP_PUBLISH;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

### rtl/core/wev_back.sv
// Back end: channel state, ring memory, shared multiplier, serial divider
// and output register. Depends on wev_pkg.
module wev_back #(
  parameter int unsigned CHANNELS = wev_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW   = wev_pkg::WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  wev_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic [31:0]        tick_scale_i,
  input  logic [2:0]         active_channels_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wev_pkg::out_word_t out_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned HD_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FL_W   = $clog2(WINDOW + 1);
  localparam int unsigned DEPTH  = CHANNELS * WINDOW;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DS_W   = 17 + $clog2(WINDOW);
  localparam int unsigned IS_W   = 32 + $clog2(WINDOW);
  localparam int unsigned DEN_W  = IS_W + 16;
  localparam int unsigned N_W    = DS_W + 52;
  localparam int unsigned CNT_W  = $clog2(N_W);
  localparam int unsigned NMAX   = (CHANNELS < 4) ? CHANNELS : 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EV_UPD, ST_P_POS, ST_P_DS, ST_P_LO, ST_P_HI,
    ST_P_SUM, ST_P_DIV, ST_P_RND, ST_P_OUT
  } state_e;

  state_e state_q;

  logic [31:0]              pos_q   [CHANNELS];
  logic [31:0]              prev_q  [CHANNELS];
  logic [FL_W-1:0]          fill_q  [CHANNELS];
  logic [HD_W-1:0]          head_q  [CHANNELS];
  logic signed [DS_W-1:0]   dsum_q  [CHANNELS];
  logic [IS_W-1:0]          isum_q  [CHANNELS];
  logic [CHANNELS-1:0]      seen_q;
  logic [31:0]              pub_cnt_q;

  logic [47:0]              ring_mem [DEPTH];
  logic [47:0]              ring_rd_q;
  logic [ADDR_W-1:0]        addr_q;
  logic                     ring_we;
  logic [ADDR_W-1:0]        rd_addr;
  logic [47:0]              ring_wdata;

  wev_pkg::cmd_t            cur_q;
  logic [CH_W-1:0]          k_q;
  logic [63:0]              mul_q;
  logic [31:0]              ahi_q;
  logic [63:0]              plo_q;
  logic [47:0]              posr_q;
  logic [N_W-1:0]           num_q;
  logic [DEN_W-1:0]         rem_q;
  logic [31:0]              quo_q;
  logic                     sat_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [31:0]       vel_q;
  logic                     out_valid_q;
  wev_pkg::out_word_t       out_q;

  logic [CH_W-1:0]          cur_ch, new_ch, k_ch;
  logic [31:0]              mul_a, mul_b;
  logic [2:0]               n_pub;
  logic                     k_last;
  logic [31:0]              pmag;
  logic [DS_W-1:0]          dmag;
  logic                     dneg;
  logic [32:0]              limit;
  logic [DEN_W-1:0]         den;
  logic [DEN_W:0]           trial;
  logic                     tbit;
  logic [32:0]              qrnd;
  logic [31:0]              qfin;
  logic [47:0]              rpos;
  logic [31:0]              dt;
  logic                     full;
  logic signed [15:0]       old_d;
  logic [31:0]              old_i;
  logic                     out_free;

  assign new_ch = CH_W'(cmd_i.channel);
  assign cur_ch = CH_W'(cur_q.channel);
  assign k_ch   = k_q;
  assign rd_addr = ADDR_W'(ADDR_W'(new_ch) * ADDR_W'(WINDOW) + ADDR_W'(head_q[new_ch]));

  assign n_pub  = (active_channels_i == 3'd0) ? 3'd1 :
                  (active_channels_i > 3'(NMAX)) ? 3'(NMAX) : active_channels_i;
  assign k_last = (3'(k_q) + 3'd1 == n_pub);

  assign pmag  = pos_q[k_ch][31] ? 32'(-pos_q[k_ch]) : pos_q[k_ch];
  assign dneg  = dsum_q[k_ch] < 0;
  assign dmag  = dneg ? DS_W'(-dsum_q[k_ch]) : DS_W'(dsum_q[k_ch]);
  assign limit = dneg ? 33'h080000000 : 33'h07FFFFFFF;
  assign den   = {isum_q[k_ch], 16'd0};

  always_comb begin
    case (state_q)
      ST_P_POS: begin
        mul_a = pmag;
        mul_b = tick_scale_i;
      end
      ST_P_DS: begin
        mul_a = 32'(dmag);
        mul_b = tick_scale_i;
      end
      ST_P_LO: begin
        mul_a = mul_q[31:0];
        mul_b = wev_pkg::US_PER_S;
      end
      default: begin
        mul_a = ahi_q;
        mul_b = wev_pkg::US_PER_S;
      end
    endcase
  end

  assign rpos  = 48'((mul_q + 64'd32768) >> 16);
  assign trial = {rem_q, num_q[N_W-1]};
  assign tbit  = trial >= {1'b0, den};
  assign qrnd  = {1'b0, quo_q} + 33'({rem_q, 1'b0} >= {1'b0, den});
  assign qfin  = (sat_q || qrnd > limit) ? limit[31:0] : qrnd[31:0];

  assign dt     = cur_q.stamp - prev_q[cur_ch];
  assign full   = (fill_q[cur_ch] == FL_W'(WINDOW));
  assign old_d  = ring_rd_q[47:32];
  assign old_i  = ring_rd_q[31:0];
  assign ring_we    = (state_q == ST_EV_UPD);
  assign ring_wdata = {cur_q.delta, dt};

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[addr_q] <= ring_wdata;
    end
    ring_rd_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      pub_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_q[c]  <= '0;
        prev_q[c] <= '0;
        fill_q[c] <= '0;
        head_q[c] <= '0;
        dsum_q[c] <= '0;
        isum_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_P_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cur_q  <= cmd_i;
            addr_q <= rd_addr;
            case (cmd_i.op)
              wev_pkg::OP_EVENT: state_q <= ST_EV_UPD;
              wev_pkg::OP_POLL: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (seen_q[c]) begin
                    seen_q[c] <= 1'b0;
                  end else begin
                    fill_q[c] <= '0;
                    head_q[c] <= '0;
                    dsum_q[c] <= '0;
                    isum_q[c] <= '0;
                  end
                end
              end
              wev_pkg::OP_PUBLISH: begin
                k_q     <= '0;
                state_q <= ST_P_POS;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_EV_UPD: begin
          dsum_q[cur_ch] <= dsum_q[cur_ch] + DS_W'(cur_q.delta)
                            - (full ? DS_W'(old_d) : DS_W'(0));
          isum_q[cur_ch] <= isum_q[cur_ch] + IS_W'(dt) - (full ? IS_W'(old_i) : IS_W'(0));
          if (!full) begin
            fill_q[cur_ch] <= fill_q[cur_ch] + FL_W'(1);
          end
          head_q[cur_ch] <= (head_q[cur_ch] == HD_W'(WINDOW - 1)) ? '0
                            : head_q[cur_ch] + HD_W'(1);
          prev_q[cur_ch] <= cur_q.stamp;
          pos_q[cur_ch]  <= pos_q[cur_ch] + 32'(cur_q.delta);
          seen_q[cur_ch] <= 1'b1;
          state_q        <= ST_IDLE;
        end
        ST_P_POS: begin
          mul_q   <= mul_a * mul_b;
          state_q <= ST_P_DS;
        end
        ST_P_DS: begin
          posr_q  <= pos_q[k_ch][31] ? ~rpos + 48'd1 : rpos;
          mul_q   <= mul_a * mul_b;
          state_q <= ST_P_LO;
        end
        ST_P_LO: begin
          ahi_q   <= mul_q[63:32];
          mul_q   <= mul_a * mul_b;
          state_q <= ST_P_HI;
        end
        ST_P_HI: begin
          plo_q   <= mul_q;
          mul_q   <= mul_a * mul_b;
          state_q <= ST_P_SUM;
        end
        ST_P_SUM: begin
          num_q <= N_W'(plo_q) + (N_W'(mul_q) << 32);
          rem_q <= '0;
          quo_q <= '0;
          sat_q <= 1'b0;
          cnt_q <= CNT_W'(N_W - 1);
          if (fill_q[k_ch] == '0 || dsum_q[k_ch] == '0) begin
            vel_q   <= '0;
            state_q <= ST_P_OUT;
          end else if (isum_q[k_ch] == '0) begin
            vel_q   <= dneg ? 32'(-limit[31:0]) : limit[31:0];
            state_q <= ST_P_OUT;
          end else begin
            state_q <= ST_P_DIV;
          end
        end
        ST_P_DIV: begin
          num_q <= num_q << 1;
          rem_q <= tbit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
          quo_q <= {quo_q[30:0], tbit};
          if (tbit && 32'(cnt_q) >= 32'd32) begin
            sat_q <= 1'b1;
          end
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_P_RND;
          end
        end
        ST_P_RND: begin
          vel_q   <= dneg ? 32'(-qfin) : qfin;
          state_q <= ST_P_OUT;
        end
        ST_P_OUT: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.sequence_res   <= pub_cnt_q;
            out_q.wheel          <= 2'(k_q);
            out_q.position_rad   <= posr_q;
            out_q.velocity_rad_s <= vel_q;
            out_q.last           <= k_last;
            if (k_last) begin
              pub_cnt_q <= pub_cnt_q + 32'd1;
              state_q   <= ST_IDLE;
            end else begin
              k_q     <= k_q + CH_W'(1);
              state_q <= ST_P_POS;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/core/windowed_encoder_velocity.sv
// Top level of the windowed encoder velocity estimator.
// Holds the configuration registers; instantiates wev_front and wev_back.
// Depends on wev_pkg.
//
// Events, poll ticks and publish requests enter through a two-word command
// queue; the back end handles a change event as a ring read, then an update,
// a poll tick in the state that takes the command, and a publish by taking
// the command and then, per reported channel, four passes through the shared
// 32x32 multiplier, divider setup, the one-bit-per-cycle velocity divider over
// an N = 69 + log2(WINDOW) bit numerator (73 at the default window) and rounding,
// both skipped when a sum is zero, and the output load. Results leave through an
// output register, so the back end moves on while a word waits to be taken.
module windowed_encoder_velocity #(
  parameter int unsigned CHANNELS = wev_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW   = wev_pkg::WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wev_pkg::in_word_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wev_pkg::out_word_t out_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  logic [31:0]   tick_scale_q;
  logic [2:0]    active_channels_q;
  logic          cmd_valid, cmd_pop;
  wev_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_scale_q      <= '0;
      active_channels_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wev_pkg::CFG_TICK_SCALE:      tick_scale_q      <= cfg_wdata_i;
        wev_pkg::CFG_ACTIVE_CHANNELS: active_channels_q <= cfg_wdata_i[2:0];
        default: tick_scale_q <= tick_scale_q;
      endcase
    end
  end

  wev_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  wev_back #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .tick_scale_i      (tick_scale_q),
    .active_channels_i (active_channels_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_o             (out_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of windowed_encoder_velocity: random and directed events,
// polls and publishes, checked against a built-in window velocity predictor.
// Depends on wev_pkg and the windowed_encoder_velocity RTL.
module tb_top;

  localparam int          NCH       = 4;
  localparam int          WIN       = 16;
  localparam int          BLOCK_LAT = 400;
  localparam int          HOLD_LEN  = 900;
  localparam int          LIMIT     = 1_000_000;
  localparam int          RANDOM_N  = 300;
  localparam logic [1:0]  FUNC_SPARE = 2'd3;

  class wheel_scoreboard;
    logic [31:0]        tick_scale;
    logic [2:0]         active;
    logic [31:0]        tick_pos [NCH];
    logic [31:0]        prev_t [NCH];
    logic signed [15:0] delta_ring [NCH][WIN];
    logic [31:0]        gap_ring [NCH][WIN];
    int                 fill [NCH];
    int                 head [NCH];
    longint             delta_sum [NCH];
    longint             gap_sum [NCH];
    bit                 seen [NCH];
    logic [31:0]        publish_cnt;
    wev_pkg::out_word_t pending_q [$];
    int                 errors;
    int                 results;

    function new();
      tick_scale    = '0;
      active        = 3'd4;
      publish_cnt   = '0;
      errors        = 0;
      results       = 0;
      for (int c = 0; c < NCH; c++) begin
        tick_pos[c] = '0;
        prev_t[c]   = '0;
        fill[c]     = 0;
        head[c]     = 0;
        delta_sum[c] = 0;
        gap_sum[c]  = 0;
        seen[c]     = 1'b0;
      end
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == wev_pkg::CFG_TICK_SCALE) tick_scale = data;
      else active = data[2:0];
    endfunction

    function logic [47:0] position_of(int c);
      logic [63:0] mag;
      logic [63:0] r;
      logic        neg;
      neg = tick_pos[c][31];
      mag = neg ? 64'(-$signed({32'hFFFF_FFFF, tick_pos[c]})) : 64'(tick_pos[c]);
      r = (mag * 64'(tick_scale) + 64'd32768) >> 16;
      if (neg) r = -r;
      return r[47:0];
    endfunction

    function logic [31:0] velocity_of(int c);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      logic [127:0] r;
      logic [63:0]  dmag;
      logic [31:0]  lim;
      logic [31:0]  v;
      bit           sat;
      longint       ds;
      ds = delta_sum[c];
      if (fill[c] == 0 || ds == 0) return '0;
      dmag = ds < 0 ? -ds : ds;
      lim  = ds < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat  = 1'b0;
      v    = '0;
      if (gap_sum[c] == 0) begin
        sat = 1'b1;
      end else begin
        num = 128'(dmag) * 128'(tick_scale) * 128'(wev_pkg::US_PER_S);
        den = 128'(gap_sum[c]) << 16;
        q = num / den;
        r = num % den;
        if (q >= 128'h1_0000_0000) begin
          sat = 1'b1;
        end else begin
          if ((r << 1) >= den) q = q + 1;
          if (q > 128'(lim)) sat = 1'b1;
          v = q[31:0];
        end
      end
      if (sat) v = lim;
      if (ds < 0) v = -v;
      return v;
    endfunction

    function void note_word(wev_pkg::in_word_t w);
      int        c;
      int        n;
      logic [31:0] dt;
      wev_pkg::out_word_t e;
      case (w.func)
        wev_pkg::FUNC_EVENT: begin
          c  = w.channel;
          dt = w.timestamp_us - prev_t[c];
          if (fill[c] >= WIN) begin
            delta_sum[c] -= delta_ring[c][head[c]];
            gap_sum[c]   -= gap_ring[c][head[c]];
          end else begin
            fill[c]++;
          end
          delta_ring[c][head[c]] = w.tick_delta;
          gap_ring[c][head[c]]   = dt;
          delta_sum[c] += w.tick_delta;
          gap_sum[c]   += dt;
          head[c]  = (head[c] + 1) % WIN;
          prev_t[c] = w.timestamp_us;
          tick_pos[c] = tick_pos[c] + 32'($signed(w.tick_delta));
          seen[c] = 1'b1;
        end
        wev_pkg::FUNC_POLL: begin
          for (int k = 0; k < NCH; k++) begin
            if (seen[k]) begin
              seen[k] = 1'b0;
            end else begin
              fill[k] = 0;
              head[k] = 0;
              delta_sum[k] = 0;
              gap_sum[k] = 0;
            end
          end
        end
        wev_pkg::FUNC_PUBLISH: begin
          n = active;
          if (n < 1) n = 1;
          if (n > NCH) n = NCH;
          for (int k = 0; k < n; k++) begin
            e.sequence_res   = publish_cnt;
            e.wheel          = 2'(k);
            e.position_rad   = position_of(k);
            e.velocity_rad_s = velocity_of(k);
            e.last           = (k + 1 == n);
            pending_q = {pending_q, e};
          end
          publish_cnt++;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_word(wev_pkg::out_word_t got);
      wev_pkg::out_word_t e;
      results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result word: wheel %0d seq %0d", got.wheel, got.sequence_res);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.sequence_res !== e.sequence_res) begin
        $error("sequence_res expected %0d actual %0d", e.sequence_res, got.sequence_res);
        errors++;
      end
      if (got.wheel !== e.wheel) begin
        $error("wheel expected %0d actual %0d", e.wheel, got.wheel);
        errors++;
      end
      if (got.position_rad !== e.position_rad) begin
        $error("position_rad expected %0d actual %0d", e.position_rad, got.position_rad);
        errors++;
      end
      if (got.velocity_rad_s !== e.velocity_rad_s) begin
        $error("velocity_rad_s expected %0d actual %0d", e.velocity_rad_s,
               got.velocity_rad_s);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last expected %0d actual %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  wev_pkg::in_word_t  in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  wev_pkg::out_word_t out_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;

  wheel_scoreboard sb = new();
  int          send_pct = 0;
  int          recv_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles = 0;
  int          words_in = 0;
  logic [31:0] now_us = '0;

  windowed_encoder_velocity u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_o);
  end

  task automatic send_word(wev_pkg::in_word_t w);
    in_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    words_in++;
    if ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (BLOCK_LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic wev_pkg::in_word_t make_word(logic [1:0] f, logic [1:0] ch,
                                                  logic [15:0] d, logic [31:0] t);
    wev_pkg::in_word_t w;
    w.func = f;
    w.channel = ch;
    w.tick_delta = d;
    w.timestamp_us = t;
    return w;
  endfunction

  function automatic wev_pkg::in_word_t random_word();
    int r;
    logic [15:0] d;
    r = $urandom_range(99);
    if (r < 70) begin
      case ($urandom_range(9))
        0:       now_us = $urandom();
        1:       now_us = now_us;
        default: now_us = now_us + $urandom_range(1, 3000);
      endcase
      d = ($urandom_range(9) < 2) ? 16'($urandom()) : 16'($urandom_range(0, 400) - 200);
      return make_word(wev_pkg::FUNC_EVENT, 2'($urandom()), d, now_us);
    end
    if (r < 78) begin
      return make_word(wev_pkg::FUNC_POLL, 2'($urandom()), 16'($urandom()), $urandom());
    end
    if (r < 96) begin
      return make_word(wev_pkg::FUNC_PUBLISH, 2'($urandom()), 16'($urandom()), $urandom());
    end
    return make_word(FUNC_SPARE, 2'($urandom()), 16'($urandom()), $urandom());
  endfunction

  logic [31:0] rpt_set [8];
  logic [31:0] act_set [8];

  initial begin
    rpt_set = '{32'h1000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0008_0000,
                32'h1, 32'h0123_4567, 32'h4000_0000, 32'h00C0_FFEE};
    act_set = '{32'd4, 32'd4, 32'd0, 32'd7, 32'd3, 32'd5, 32'd2, 32'd1};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 8; ph++) begin
      send_pct = (ph < 3) ? 33 : (ph < 6) ? 47 : 0;
      recv_pct = (ph < 3) ? 47 : (ph < 6) ? 33 : 0;
      if (ph == 7) rpt_set[ph] = $urandom();
      write_reg(wev_pkg::CFG_TICK_SCALE, rpt_set[ph]);
      write_reg(wev_pkg::CFG_ACTIVE_CHANNELS, act_set[ph]);
      if (ph == 0) begin
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd0, 16'd5, 32'd0));
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd3, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd1, 16'sd32767, 32'd100));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd1, 16'sd32767, 32'd101));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd2, 16'h8000, 32'hFFFF_FFFF));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd2, 16'h8000, 32'd5));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd3, 16'd0, 32'd50));
        send_word(make_word(FUNC_SPARE, 2'd3, 16'hFFFF, 32'hFFFF_FFFF));
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_POLL, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_POLL, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_EVENT, 2'd0, 16'd3, 32'd1000));
        send_word(make_word(wev_pkg::FUNC_POLL, 2'd0, 16'd0, 32'd0));
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd0, 16'd0, 32'd0));
      end
      if (ph == 1) hold_req++;
      for (int i = 0; i < RANDOM_N / 8; i++) send_word(random_word());
      if (ph == 1) for (int i = 0; i < 8; i++)
        send_word(make_word(wev_pkg::FUNC_PUBLISH, 2'd0, 16'd0, 32'd0));
      drain();
    end

    $display("Sent %0d input words over 8 register settings; checked %0d result words.",
             words_in, sb.results);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
